FILE: rtl/rit_pkg.sv
`default_nettype none
package rit_pkg;

  localparam int MAX_NODES  = 32;
  localparam int NODE_BITS  = 5;
  localparam int CNT_BITS   = 6;
  localparam int VALUE_BITS = 16;
  localparam int DIST_DEPTH = MAX_NODES * MAX_NODES;
  localparam int TOTAL_BITS = 23;
  localparam int SUM_BITS   = 24;
  localparam logic signed [SUM_BITS-1:0] TOTAL_MAX = 24'sd8388607;

  // input item kinds
  typedef enum logic [1:0] {
    KIND_DIST  = 2'd0,
    KIND_PROF  = 2'd1,
    KIND_BUILD = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_NODE_COUNT = 2'd0,
    REG_USE_PROFIT = 2'd1,
    REG_REGRET_W   = 2'd2,
    REG_GREEDY_W   = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SEED_RD,
    S_SEED_CMP,
    S_SEED_D2,
    S_SEED_P2,
    S_SEED_W2,
    S_RND_START,
    S_V_CHK,
    S_E_NEXT,
    S_E_RD1,
    S_E_RD2,
    S_E_RD3,
    S_E_EVAL,
    S_SCORE,
    S_CMP,
    S_INSERT,
    S_INS_A,
    S_INS_B,
    S_INS_C,
    S_OUT_FIRST,
    S_OUT_RD,
    S_OUT_WAIT
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/rit_if.sv
`default_nettype none
interface rit_in_if;
  import rit_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [1:0]            kind;
  logic [NODE_BITS-1:0]  row;
  logic [NODE_BITS-1:0]  column;
  logic [VALUE_BITS-1:0] value;
  logic [NODE_BITS-1:0]  origin;
  modport source (output valid, kind, row, column, value, origin, input ready);
  modport sink (input valid, kind, row, column, value, origin, output ready);
endinterface

interface rit_out_if;
  import rit_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [NODE_BITS-1:0]        tour_node;
  logic                        last;
  logic [TOTAL_BITS-1:0]       tour_distance;
  logic [TOTAL_BITS-1:0]       tour_profit;
  logic signed [SUM_BITS-1:0]  objective;
  modport source (output valid, tour_node, last, tour_distance, tour_profit, objective,
                  input ready);
  modport sink (input valid, tour_node, last, tour_distance, tour_profit, objective,
                output ready);
endinterface
`default_nettype wire

FILE: rtl/rit_ram.sv
`default_nettype none
module rit_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/regret_insertion_tour_top.sv
// channel  dir  payload                                                handshake
// in_ch    in   kind, row, column, value, origin                       valid/ready
// out_ch   out  tour_node, last, tour_distance, tour_profit, objective  valid/ready
// apb      in   paddr, pwdata (4 registers at 4*i)                     psel/penable
//
// a build tests every tour edge for each candidate node, its pace set by the
// single read port of the distance memory (three reads and one link read per
// edge test). tour entries then leave one by one as the output takes them;
// n+1 results per build.
// rst is synchronous; memory contents are undefined until loaded.
// input is taken only between builds; a stalled output holds the walk.
`default_nettype none
module regret_insertion_tour_top
  import rit_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  rit_in_if.sink           in_ch,
  rit_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  // configuration
  logic [CNT_BITS-1:0]   node_count;
  logic                  use_profit;
  logic signed [15:0]    regret_weight;
  logic signed [15:0]    greedy_weight;

  state_t state, state_next;

  // build registers
  logic [CNT_BITS-1:0]   n, v, step;
  logic [NODE_BITS-1:0]  start, s2, u, w, cur;
  logic                  have;
  logic [VALUE_BITS-1:0] mind, pv;
  logic [MAX_NODES-1:0]  visited;
  logic [VALUE_BITS:0]   acc;
  logic signed [18:0]    bv, sv;
  logic                  bok, sok;
  logic [NODE_BITS-1:0]  cand_u;
  logic signed [17:0]    cand_dd;
  logic signed [35:0]    prod_r;
  logic signed [34:0]    prod_g;
  logic                  any;
  logic signed [36:0]    best_score;
  logic [NODE_BITS-1:0]  pick_node, best_u;
  logic signed [17:0]    best_dd;
  logic signed [SUM_BITS-1:0] dsum, psum;
  logic                  out_valid;

  // memory ports
  logic                            dist_we, dist_re, prof_we, prof_re, link_we, link_re;
  logic [2*NODE_BITS-1:0]          dist_waddr, dist_raddr;
  logic [VALUE_BITS-1:0]           dist_rdata, prof_rdata;
  logic [NODE_BITS-1:0]            prof_waddr, prof_raddr, link_waddr, link_raddr;
  logic [NODE_BITS-1:0]            link_wdata, link_rdata;

  logic                  in_acc, slot_free, cfg_wr;
  logic [CNT_BITS-1:0]   n_clamp;
  logic [NODE_BITS-1:0]  v_idx;
  logic signed [17:0]    dd;
  logic signed [18:0]    f;
  logic signed [36:0]    score;
  logic signed [SUM_BITS-1:0] dist_sat, prof_sat;

  rit_ram #(.WIDTH(VALUE_BITS), .DEPTH(DIST_DEPTH)) u_dist (
    .clk(clk), .we(dist_we), .waddr(dist_waddr), .wdata(in_ch.value),
    .re(dist_re), .raddr(dist_raddr), .rdata(dist_rdata)
  );

  rit_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_NODES)) u_prof (
    .clk(clk), .we(prof_we), .waddr(prof_waddr), .wdata(in_ch.value),
    .re(prof_re), .raddr(prof_raddr), .rdata(prof_rdata)
  );

  // successor of each node on the tour, read while walking the edges
  rit_ram #(.WIDTH(NODE_BITS), .DEPTH(MAX_NODES)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .re(link_re), .raddr(link_raddr), .rdata(link_rdata)
  );

  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid || out_ch.ready;
  assign v_idx       = v[NODE_BITS-1:0];
  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite;

  // node count clamp
  always_comb begin
    if (node_count < CNT_BITS'(2)) begin
      n_clamp = CNT_BITS'(2);
    end else if (node_count > CNT_BITS'(MAX_NODES)) begin
      n_clamp = CNT_BITS'(MAX_NODES);
    end else begin
      n_clamp = node_count;
    end
  end

  // insertion value of the current edge
  assign dd    = 18'(signed'({1'b0, acc})) - 18'(signed'({2'b00, dist_rdata}));
  assign f     = use_profit ? (19'(signed'({1'b0, pv})) - 19'(dd)) : -19'(dd);
  assign score = 37'(prod_r) + 37'(prod_g);

  // saturated totals
  always_comb begin
    if (dsum < 0) begin
      dist_sat = '0;
    end else if (dsum > TOTAL_MAX) begin
      dist_sat = TOTAL_MAX;
    end else begin
      dist_sat = dsum;
    end
    if (psum < 0) begin
      prof_sat = '0;
    end else if (psum > TOTAL_MAX) begin
      prof_sat = TOTAL_MAX;
    end else begin
      prof_sat = psum;
    end
  end

  // config read back
  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_NODE_COUNT: prdata = {26'd0, node_count};
      REG_USE_PROFIT: prdata = {31'd0, use_profit};
      REG_REGRET_W:   prdata = {{16{regret_weight[15]}}, regret_weight};
      REG_GREEDY_W:   prdata = {{16{greedy_weight[15]}}, greedy_weight};
      default:        prdata = '0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc && kind_t'(in_ch.kind) == KIND_BUILD) begin
          state_next = S_SEED_RD;
        end
      end
      S_SEED_RD: begin
        if (v >= n) begin
          state_next = S_SEED_D2;
        end else if (v_idx != start) begin
          state_next = S_SEED_CMP;
        end
      end
      S_SEED_CMP:  state_next = S_SEED_RD;
      S_SEED_D2:   state_next = S_SEED_P2;
      S_SEED_P2:   state_next = S_SEED_W2;
      S_SEED_W2:   state_next = (CNT_BITS'(2) < n) ? S_RND_START : S_OUT_FIRST;
      S_RND_START: state_next = S_V_CHK;
      S_V_CHK: begin
        if (v >= n) begin
          state_next = S_INSERT;
        end else if (!visited[v_idx]) begin
          state_next = S_E_NEXT;
        end
      end
      S_E_NEXT:    state_next = S_E_RD1;
      S_E_RD1:     state_next = S_E_RD2;
      S_E_RD2:     state_next = S_E_RD3;
      S_E_RD3:     state_next = S_E_EVAL;
      S_E_EVAL:    state_next = (w == start) ? S_SCORE : S_E_NEXT;
      S_SCORE:     state_next = S_CMP;
      S_CMP:       state_next = S_V_CHK;
      S_INSERT:    state_next = S_INS_A;
      S_INS_A:     state_next = S_INS_B;
      S_INS_B:     state_next = S_INS_C;
      S_INS_C:     state_next = (step + CNT_BITS'(1) < n) ? S_RND_START : S_OUT_FIRST;
      S_OUT_FIRST: state_next = slot_free ? S_OUT_RD : S_OUT_FIRST;
      S_OUT_RD:    state_next = S_OUT_WAIT;
      S_OUT_WAIT: begin
        if (slot_free) begin
          state_next = (link_rdata == start) ? S_IDLE : S_OUT_RD;
        end
      end
      default:     state_next = S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    dist_we    = 1'b0;
    dist_waddr = {in_ch.row, in_ch.column};
    prof_we    = 1'b0;
    prof_waddr = in_ch.row;
    dist_re    = 1'b0;
    dist_raddr = {start, v_idx};
    prof_re    = 1'b0;
    prof_raddr = start;
    link_we    = 1'b0;
    link_waddr = start;
    link_wdata = s2;
    link_re    = 1'b0;
    link_raddr = u;
    unique case (state)
      S_IDLE: begin
        dist_we = in_acc && kind_t'(in_ch.kind) == KIND_DIST;
        prof_we = in_acc && kind_t'(in_ch.kind) == KIND_PROF;
      end
      S_SEED_RD: begin
        dist_re = 1'b1;
      end
      S_SEED_D2: begin
        dist_re    = 1'b1;
        dist_raddr = {s2, start};
        prof_re    = 1'b1;
      end
      S_SEED_P2: begin
        prof_re    = 1'b1;
        prof_raddr = s2;
        link_we    = 1'b1;
      end
      S_SEED_W2: begin
        link_we    = 1'b1;
        link_waddr = s2;
        link_wdata = start;
      end
      S_V_CHK: begin
        prof_re    = 1'b1;
        prof_raddr = v_idx;
      end
      S_E_NEXT: begin
        link_re = 1'b1;
      end
      S_E_RD1: begin
        dist_re    = 1'b1;
        dist_raddr = {u, v_idx};
      end
      S_E_RD2: begin
        dist_re    = 1'b1;
        dist_raddr = {v_idx, w};
      end
      S_E_RD3: begin
        dist_re    = 1'b1;
        dist_raddr = {u, w};
      end
      S_INSERT: begin
        link_re    = 1'b1;
        link_raddr = best_u;
      end
      S_INS_A: begin
        link_we    = 1'b1;
        link_waddr = pick_node;
        link_wdata = link_rdata;
      end
      S_INS_B: begin
        link_we    = 1'b1;
        link_waddr = best_u;
        link_wdata = pick_node;
        prof_re    = 1'b1;
        prof_raddr = pick_node;
      end
      S_OUT_RD: begin
        link_re    = 1'b1;
        link_raddr = cur;
      end
      default: begin
      end
    endcase
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      visited       <= '0;
      node_count    <= CNT_BITS'(32);
      use_profit    <= 1'b1;
      regret_weight <= 16'sd256;
      greedy_weight <= 16'sd0;
    end else begin
      state <= state_next;
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr) begin
        unique case (reg_idx_t'(paddr[3:2]))
          REG_NODE_COUNT: node_count    <= pwdata[CNT_BITS-1:0];
          REG_USE_PROFIT: use_profit    <= pwdata[0];
          REG_REGRET_W:   regret_weight <= signed'(pwdata[15:0]);
          REG_GREEDY_W:   greedy_weight <= signed'(pwdata[15:0]);
          default: begin
          end
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc && kind_t'(in_ch.kind) == KIND_BUILD) begin
            n    <= n_clamp;
            v    <= '0;
            have <= 1'b0;
            mind <= '0;
            s2   <= '0;
            if (CNT_BITS'(in_ch.origin) >= n_clamp) begin
              start   <= '0;
              visited <= MAX_NODES'(1);
            end else begin
              start   <= in_ch.origin;
              visited <= MAX_NODES'(1) << in_ch.origin;
            end
          end
        end
        S_SEED_RD: begin
          if (v < n && v_idx == start) begin
            v <= v + CNT_BITS'(1);
          end
        end
        S_SEED_CMP: begin
          if (!have || dist_rdata < mind) begin
            have <= 1'b1;
            mind <= dist_rdata;
            s2   <= v_idx;
          end
          v <= v + CNT_BITS'(1);
        end
        S_SEED_P2: begin
          dsum <= SUM_BITS'(mind) + SUM_BITS'(dist_rdata);
          psum <= SUM_BITS'(prof_rdata);
        end
        S_SEED_W2: begin
          psum        <= psum + SUM_BITS'(prof_rdata);
          visited[s2] <= 1'b1;
          step        <= CNT_BITS'(2);
        end
        S_RND_START: begin
          v   <= '0;
          any <= 1'b0;
        end
        S_V_CHK: begin
          if (v < n) begin
            if (visited[v_idx]) begin
              v <= v + CNT_BITS'(1);
            end else begin
              u   <= start;
              bok <= 1'b0;
              sok <= 1'b0;
            end
          end
        end
        S_E_NEXT: begin
          pv <= prof_rdata;
        end
        S_E_RD1: begin
          w <= link_rdata;
        end
        S_E_RD2: begin
          acc <= {1'b0, dist_rdata};
        end
        S_E_RD3: begin
          acc <= acc + {1'b0, dist_rdata};
        end
        S_E_EVAL: begin
          if (!bok || f > bv) begin
            if (bok) begin
              sv  <= bv;
              sok <= 1'b1;
            end
            bv      <= f;
            bok     <= 1'b1;
            cand_u  <= u;
            cand_dd <= dd;
          end else if (!sok || f > sv) begin
            sv  <= f;
            sok <= 1'b1;
          end
          u <= w;
        end
        S_SCORE: begin
          prod_r <= 36'(regret_weight) * 36'(20'(bv) - 20'(sv));
          prod_g <= 35'(greedy_weight) * 35'(bv);
        end
        S_CMP: begin
          if (!any || score > best_score) begin
            any        <= 1'b1;
            best_score <= score;
            pick_node  <= v_idx;
            best_u     <= cand_u;
            best_dd    <= cand_dd;
          end
          v <= v + CNT_BITS'(1);
        end
        S_INS_B: begin
          visited[pick_node] <= 1'b1;
          dsum               <= dsum + SUM_BITS'(best_dd);
        end
        S_INS_C: begin
          psum <= psum + SUM_BITS'(prof_rdata);
          step <= step + CNT_BITS'(1);
        end
        S_OUT_FIRST: begin
          if (slot_free) begin
            out_valid            <= 1'b1;
            out_ch.tour_node     <= start;
            out_ch.last          <= 1'b0;
            out_ch.tour_distance <= dist_sat[TOTAL_BITS-1:0];
            out_ch.tour_profit   <= prof_sat[TOTAL_BITS-1:0];
            out_ch.objective     <= prof_sat - dist_sat;
            cur                  <= start;
          end
        end
        S_OUT_WAIT: begin
          if (slot_free) begin
            out_valid        <= 1'b1;
            out_ch.tour_node <= link_rdata;
            out_ch.last      <= (link_rdata == start);
            cur              <= link_rdata;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_ch.valid = out_valid;

`ifndef SYNTH
  // loads only land while no build runs
  a_dist_write_idle: assert property (@(posedge clk) disable iff (rst)
    dist_we |-> state == S_IDLE)
    else $error("distance write during build");

  // the start node stays on the tour through every round
  a_start_visited: assert property (@(posedge clk) disable iff (rst)
    state == S_V_CHK |-> visited[start])
    else $error("start node lost from tour");

  // one node joins per round
  a_visit_count: assert property (@(posedge clk) disable iff (rst)
    state == S_INS_C |-> $countones(visited) == 32'(step) + 32'd1)
    else $error("visited count out of step");

  // the closing entry ends the walk
  a_walk_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT_WAIT && slot_free && link_rdata == start) |=> state == S_IDLE)
    else $error("walk did not end on return to start");
`endif

endmodule
`default_nettype wire
